// File: hw/rtl/wsd_pkg.sv
// Shared types and codes for the WebSocket deframer / unmasker.
package wsd_pkg;

    // Header byte layout and length markers
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned KEY_BYTES = 4;
    localparam logic [6:0]  LEN_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_EXT64 = 7'd127;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LEN64    = 2'd1,
        ERR_UNMASKED = 2'd2
    } t_err;

    // One result item
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       last_of_frame;
        logic [1:0] error_code;
    } t_result;

    // Input stage toward the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_stage;

    // Handshake between parser and output register
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_req;

endpackage

// File: hw/rtl/wsd_ifs.sv
// Stream channel interfaces: raw byte input and decoded result output.
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_of_frame;
    logic [1:0] error_code;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_opcode, output final_fragment,
                    output last_of_frame, output error_code, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_opcode, input final_fragment,
                    input last_of_frame, input error_code, output ready);
endinterface

// File: hw/rtl/websocket_frame_deframe_unmask_top.sv
// Top level of the WebSocket client frame deframer and unmasker.
//
//  channel        dir  payload                                  handshake
//  i_byte_chan    in   stream_byte[7:0]                         valid/ready
//  o_result_chan  out  result_kind, payload_byte, frame_opcode, valid/ready
//                      final_fragment, last_of_frame, error_code
//
// One byte per cycle sustained while the sink is ready: input register, one
// level of parse/XOR logic, output register. A byte's result is loaded into
// the output register as the parser consumes the byte. Synchronous active-low
// reset returns the parser to the first header byte and empties both registers.
// A stalled sink holds the output register; the input register keeps taking
// bytes that produce no result (header, length, mask key) while a result waits.
module websocket_frame_deframe_unmask_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsd_byte_if.sink      i_byte_chan,
    wsd_result_if.source  o_result_chan
);
    import wsd_pkg::*;

    t_in_stage stage;
    t_res_req  req;
    t_result   res;
    logic      consume;
    logic      space;

    wsd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte_chan.valid),
        .i_data    (i_byte_chan.stream_byte),
        .o_ready   (i_byte_chan.ready),
        .i_consume (consume),
        .o_stage   (stage)
    );

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .i_res_space (space),
        .o_consume   (consume),
        .o_req       (req)
    );

    wsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_space (space),
        .i_ready (o_result_chan.ready),
        .o_valid (o_result_chan.valid),
        .o_res   (res)
    );

    assign o_result_chan.result_kind    = res.result_kind;
    assign o_result_chan.payload_byte   = res.payload_byte;
    assign o_result_chan.frame_opcode   = res.frame_opcode;
    assign o_result_chan.final_fragment = res.final_fragment;
    assign o_result_chan.last_of_frame  = res.last_of_frame;
    assign o_result_chan.error_code     = res.error_code;

endmodule

// File: hw/rtl/wsd_in_reg.sv
// Input register: holds one raw byte until the parser consumes it.
module wsd_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data,
    output logic                o_ready,
    input  logic                i_consume,
    output wsd_pkg::t_in_stage  o_stage
);
    import wsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_consume;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    // Byte holding register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// File: hw/rtl/wsd_parser.sv
// Frame header parser, mask key capture and payload unmasking.
module wsd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsd_pkg::t_in_stage  i_stage,
    input  logic                i_res_space,
    output logic                o_consume,
    output wsd_pkg::t_res_req   o_req
);
    import wsd_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [3:0]         r_opcode, n_opcode;
    logic               r_fin,    n_fin;
    logic [LEN_W-1:0]   r_remain, n_remain;
    logic [KEY_W-1:0]   r_key,    n_key;
    logic [1:0]         r_pos,    n_pos;

    logic               has_res;
    t_result            res;
    logic [7:0]         b;
    logic [6:0]         len7;
    logic [7:0]         key_sel;
    logic [LEN_W-1:0]   remain_dec;

    assign b          = i_stage.data;
    assign len7       = b[6:0];
    assign remain_dec = r_remain - LEN_W'(1);

    // Key byte for the current position, byte 0 in the top bits
    always_comb begin
        case (r_pos)
            2'd0:    key_sel = r_key[31:24];
            2'd1:    key_sel = r_key[23:16];
            2'd2:    key_sel = r_key[15:8];
            default: key_sel = r_key[7:0];
        endcase
    end

    // State registers, updated when the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_remain <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (o_consume) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_remain <= n_remain;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_remain = r_remain;
        n_key    = r_key;
        n_pos    = r_pos;
        has_res  = 1'b0;
        res.result_kind    = KIND_PAYLOAD;
        res.payload_byte   = '0;
        res.frame_opcode   = r_opcode;
        res.final_fragment = r_fin;
        res.last_of_frame  = 1'b0;
        res.error_code     = ERR_NONE;

        case (r_phase)
            PH_LENGTH: begin
                if (len7 == LEN_EXT64) begin
                    n_phase         = PH_HEADER;
                    has_res         = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_LEN64;
                end else if (!b[7]) begin
                    n_phase         = PH_HEADER;
                    has_res         = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_UNMASKED;
                end else if (len7 == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else begin
                    n_remain = {9'd0, len7};
                    n_pos    = '0;
                    n_phase  = PH_MASK;
                end
            end
            PH_EXT_HI: begin
                n_remain = {b, 8'd0};
                n_phase  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_remain = {r_remain[15:8], b};
                n_pos    = '0;
                n_phase  = PH_MASK;
            end
            PH_MASK: begin
                // Write the key byte at the current position
                case (r_pos)
                    2'd0:    n_key[31:24] = b;
                    2'd1:    n_key[23:16] = b;
                    2'd2:    n_key[15:8]  = b;
                    default: n_key[7:0]   = b;
                endcase
                if (r_pos == 2'(KEY_BYTES - 1)) begin
                    n_pos = '0;
                    if (r_remain == '0) begin
                        n_phase           = PH_HEADER;
                        has_res           = 1'b1;
                        res.result_kind   = KIND_EMPTY;
                        res.last_of_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                n_pos            = r_pos + 2'd1;
                n_remain         = remain_dec;
                has_res          = 1'b1;
                res.payload_byte = b ^ key_sel;
                if (remain_dec == '0) begin
                    n_phase           = PH_HEADER;
                    res.last_of_frame = 1'b1;
                end
            end
            default: begin
                // First header byte; unused phase codes land here too
                n_fin    = b[7];
                n_opcode = b[3:0];
                n_phase  = PH_LENGTH;
            end
        endcase
    end

    // A byte moves on unless its result has nowhere to go
    assign o_consume = i_stage.valid && (!has_res || i_res_space);
    assign o_req.valid = i_stage.valid && has_res && i_res_space;
    assign o_req.res   = res;

endmodule

// File: hw/rtl/wsd_out_reg.sv
// Output register: holds one result until the sink takes it.
module wsd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsd_pkg::t_res_req   i_req,
    output logic                o_space,
    input  logic                i_ready,
    output logic                o_valid,
    output wsd_pkg::t_result    o_res
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_res <= i_req.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
